// ===== rtl/htc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htc_pkg
// Types and constants shared by the hashed tile tag cache.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [8:0]  BUCKET_COUNT_RESET = 9'd255;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] origin_x;
    logic [63:0] origin_y;
    logic [63:0] origin_z;
    logic [7:0]  res_level;
    logic [31:0] tile_handle;
    logic [31:0] tile_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_handle;
    logic [47:0] total_bytes;
  } rsp_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [7:0]  level;
    logic [31:0] handle;
    logic [31:0] size;
    logic [31:0] stamp;
  } entry_t;

  function automatic logic [7:0] byte_weight(input logic [4:0] i);
    logic [7:0] w;
    unique case (i)
      5'd0: w = 8'd101;  5'd1: w = 8'd103;  5'd2: w = 8'd107;  5'd3: w = 8'd109;
      5'd4: w = 8'd113;  5'd5: w = 8'd127;  5'd6: w = 8'd131;  5'd7: w = 8'd137;
      5'd8: w = 8'd139;  5'd9: w = 8'd149;  5'd10: w = 8'd151; 5'd11: w = 8'd157;
      5'd12: w = 8'd163; 5'd13: w = 8'd167; 5'd14: w = 8'd173; 5'd15: w = 8'd179;
      5'd16: w = 8'd181; 5'd17: w = 8'd191; 5'd18: w = 8'd193; 5'd19: w = 8'd197;
      5'd20: w = 8'd199; 5'd21: w = 8'd211; 5'd22: w = 8'd223; 5'd23: w = 8'd227;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/htc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htc_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/hashed_tile_tag_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_tile_tag_cache
// Set-associative tile tag table keyed by 3-D origin and resolution level.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on req_valid_i/req_stall_o; one response word per
//   request leaves on rsp_valid_o/rsp_stall_i. cfg_we_i writes bucket_count;
//   the user must write it while the block is idle, as the block does not
//   enforce this. A request is hashed one byte weight per cycle (one 8x8
//   multiply-add per key byte), reduced modulo the bucket count one
//   quotient bit a cycle, then the bucket is read one way a cycle and
//   updated. The response word is registered; a new request is taken only
//   after the response word of the last one has been taken.
//   Entry data sits in one RAM of BUCKETS*WAYS entries; valid bits sit in a
//   RAM of one WAYS-bit word per bucket.
//   The response sits in an output register; while the receiver stalls the
//   block holds it and accepts no new request.
//   Reset clears the insert sequence and the byte total, sets bucket_count
//   to 255 and starts a pass over every bucket that clears the valid RAM; the
//   request input stalls until the pass ends.
// ----------------------------------------------------------------------------
module hashed_tile_tag_cache #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [8:0]    cfg_wdata_i,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire htc_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_stall_i,
  output htc_pkg::rsp_t      rsp_o
);
  import htc_pkg::*;

  localparam int Slots = BUCKETS * WAYS;
  localparam int SlotW = $clog2(Slots) > 0 ? $clog2(Slots) : 1;
  localparam int BktW  = $clog2(BUCKETS) > 0 ? $clog2(BUCKETS) : 1;
  localparam int WayW  = $clog2(WAYS) > 0 ? $clog2(WAYS) : 1;
  localparam int WcntW = $clog2(WAYS + 1);
  localparam int EntW  = $bits(entry_t);
  localparam logic [12:0] BucketsMax = 13'(BUCKETS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_RSP  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;

  logic [2:0]  state_q;
  logic [8:0]  bcnt_q;
  req_t        req_q;
  logic [31:0] hash_q;
  logic [4:0]  idx_q;
  logic [31:0] rem_q;
  logic [12:0] div_q;
  logic [BktW-1:0]  bkt_q;
  logic [BktW-1:0]  clr_q;
  logic [WcntW-1:0] wcnt_q;
  logic [31:0] seq_q;
  logic [47:0] total_q;
  logic        rd_pend_q;
  logic [WayW-1:0] rd_way_q;
  logic        free_q, hit_q;
  logic [WayW-1:0] free_way_q, hit_way_q;
  logic [31:0] hit_age_q, hit_handle_q, hit_size_q;
  rsp_t        rsp_q;

  logic [191:0] key_w;
  logic [7:0]   cur_byte;
  logic [15:0]  prod;
  logic [12:0]  n_eff;
  logic [32:0]  rem_sh;
  logic [31:0]  rem_nx;
  logic         ram_we;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  logic [EntW-1:0]  ram_wdata, ram_rdata;
  logic         vram_we;
  logic [BktW-1:0] vram_waddr;
  logic [WAYS-1:0] vram_wdata, vram_rdata;
  entry_t       rd_ent, wr_ent;
  logic         rd_match;
  logic [31:0]  rd_age;
  logic [47:0]  sum_ins;

  assign key_w    = {req_q.origin_z, req_q.origin_y, req_q.origin_x};
  assign cur_byte = key_w[8*idx_q +: 8];
  assign prod     = 16'(cur_byte) * 16'(byte_weight(idx_q));

  always_comb begin
    if (bcnt_q == 9'd0) begin
      n_eff = 13'd255;
    end else if (13'(bcnt_q) > BucketsMax) begin
      n_eff = BucketsMax;
    end else begin
      n_eff = 13'(bcnt_q);
    end
  end

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, hash_q[31 - idx_q]};
  assign rem_nx = (rem_sh >= 33'(div_q)) ? 32'(rem_sh - 33'(div_q)) : rem_sh[31:0];

  assign rd_ent   = entry_t'(ram_rdata);
  assign rd_match = vram_rdata[rd_way_q] && rd_ent.x == req_q.origin_x &&
                    rd_ent.y == req_q.origin_y && rd_ent.z == req_q.origin_z &&
                    rd_ent.level == req_q.res_level;
  assign rd_age   = seq_q - rd_ent.stamp;
  assign ram_raddr = SlotW'(bkt_q) * SlotW'(WAYS) + SlotW'(wcnt_q[WayW-1:0]);
  assign sum_ins  = total_q + 48'(req_q.tile_bytes);

  always_comb begin
    wr_ent.x      = req_q.origin_x;
    wr_ent.y      = req_q.origin_y;
    wr_ent.z      = req_q.origin_z;
    wr_ent.level  = req_q.res_level;
    wr_ent.handle = req_q.tile_handle;
    wr_ent.size   = req_q.tile_bytes;
    wr_ent.stamp  = seq_q;
  end
  assign ram_wdata = EntW'(wr_ent);
  assign ram_waddr = SlotW'(bkt_q) * SlotW'(WAYS) + SlotW'(free_way_q);
  assign ram_we    = state_q == S_UPD && req_q.opcode == OP_INSERT && free_q;

  htc_ram #(.Width(EntW), .Depth(Slots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    vram_we    = 1'b0;
    vram_waddr = bkt_q;
    vram_wdata = vram_rdata;
    if (state_q == S_CLR) begin
      vram_we    = 1'b1;
      vram_waddr = clr_q;
      vram_wdata = '0;
    end else if (state_q == S_UPD) begin
      if (req_q.opcode == OP_INSERT && free_q) begin
        vram_we                = 1'b1;
        vram_wdata[free_way_q] = 1'b1;
      end else if (req_q.opcode == OP_REMOVE && hit_q) begin
        vram_we               = 1'b1;
        vram_wdata[hit_way_q] = 1'b0;
      end
    end
  end

  htc_ram #(.Width(WAYS), .Depth(BUCKETS)) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (bkt_q),
    .rdata_o (vram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      bcnt_q    <= BUCKET_COUNT_RESET;
      seq_q     <= '0;
      total_q   <= '0;
      hash_q    <= '0;
      idx_q     <= '0;
      rem_q     <= '0;
      div_q     <= '0;
      bkt_q     <= '0;
      wcnt_q    <= '0;
      rd_pend_q <= 1'b0;
      rd_way_q  <= '0;
      free_q    <= 1'b0;
      hit_q     <= 1'b0;
      free_way_q <= '0;
      hit_way_q <= '0;
      hit_age_q <= '0;
      hit_handle_q <= '0;
      hit_size_q <= '0;
      rsp_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        bcnt_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + BktW'(1);
          if (clr_q == BktW'(BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid_i) begin
            hash_q <= '0;
            idx_q  <= '0;
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          hash_q <= hash_q + 32'(prod);
          if (idx_q == 5'd23) begin
            idx_q  <= '0;
            rem_q  <= '0;
            div_q  <= n_eff;
            state_q <= S_MOD;
          end else begin
            idx_q <= idx_q + 5'd1;
          end
        end
        S_MOD: begin
          rem_q <= rem_nx;
          if (idx_q == 5'd31) begin
            bkt_q     <= BktW'(rem_nx);
            wcnt_q    <= '0;
            rd_pend_q <= 1'b0;
            free_q    <= 1'b0;
            hit_q     <= 1'b0;
            state_q   <= S_SCAN;
          end else begin
            idx_q <= idx_q + 5'd1;
          end
        end
        S_SCAN: begin
          if (rd_pend_q) begin
            if (!free_q && !vram_rdata[rd_way_q]) begin
              free_q     <= 1'b1;
              free_way_q <= rd_way_q;
            end
            if (rd_match && (!hit_q || rd_age > hit_age_q)) begin
              hit_q        <= 1'b1;
              hit_way_q    <= rd_way_q;
              hit_age_q    <= rd_age;
              hit_handle_q <= rd_ent.handle;
              hit_size_q   <= rd_ent.size;
            end
          end
          if (wcnt_q == WcntW'(WAYS)) begin
            rd_pend_q <= 1'b0;
            if (!rd_pend_q) begin
              state_q <= S_UPD;
            end
          end else begin
            rd_pend_q <= 1'b1;
            rd_way_q  <= wcnt_q[WayW-1:0];
            wcnt_q    <= wcnt_q + WcntW'(1);
          end
        end
        S_UPD: begin
          rsp_q.status       <= ST_MISS;
          rsp_q.found_handle <= '0;
          rsp_q.total_bytes  <= total_q;
          unique case (req_q.opcode)
            OP_INSERT: begin
              if (free_q) begin
                seq_q <= seq_q + 32'd1;
                total_q <= (sum_ins < total_q) ? TOTAL_MAX : sum_ins;
                rsp_q.status       <= ST_OK;
                rsp_q.found_handle <= req_q.tile_handle;
                rsp_q.total_bytes  <= (sum_ins < total_q) ? TOTAL_MAX : sum_ins;
              end else begin
                rsp_q.status <= ST_FULL;
              end
            end
            OP_GET: begin
              if (hit_q) begin
                rsp_q.status       <= ST_OK;
                rsp_q.found_handle <= hit_handle_q;
              end
            end
            OP_REMOVE: begin
              if (hit_q) begin
                total_q <= (total_q >= 48'(hit_size_q)) ? total_q - 48'(hit_size_q) : '0;
                rsp_q.status       <= ST_OK;
                rsp_q.found_handle <= hit_handle_q;
                rsp_q.total_bytes  <=
                  (total_q >= 48'(hit_size_q)) ? total_q - 48'(hit_size_q) : '0;
              end
            end
            default: ;
          endcase
          state_q <= S_RSP;
        end
        S_RSP: begin
          if (!rsp_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_stall_o = state_q != S_IDLE;
  assign rsp_valid_o = state_q == S_RSP;
  assign rsp_o       = rsp_q;
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hashed tile tag cache. Request words come from
// a queue filled by the stimulus process and are driven with random gaps; a
// predictor keeps its own copy of the tag table and byte total and checks
// every response word, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htc_pkg::*;

  localparam int NBKT  = 256;
  localparam int NWAY  = 4;
  localparam int LIMIT = 20000;

  logic clk, rst_n;
  logic cfg_we;
  logic [8:0] cfg_wdata;
  logic req_valid, req_stall;
  req_t req;
  logic rsp_valid, rsp_stall;
  rsp_t rsp;

  hashed_tile_tag_cache #(.BUCKETS(NBKT), .WAYS(NWAY)) u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .req_valid_i(req_valid), .req_stall_o(req_stall), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_stall_i(rsp_stall), .rsp_o(rsp)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // tag table copy
  logic        tv_valid [NBKT*NWAY];
  entry_t      tv_entry [NBKT*NWAY];
  logic [31:0] ins_seq;
  logic [47:0] tot_bytes;
  logic [8:0]  nbkt_reg;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors;
  int   hold_off;
  int   idle_cycles;
  bit   stim_done;

  function automatic int bucket_of(req_t r);
    logic [31:0] h;
    logic [63:0] w [3];
    int n;
    h = '0;
    w[0] = r.origin_x; w[1] = r.origin_y; w[2] = r.origin_z;
    for (int i = 0; i < 24; i++) h += 32'(w[i/8][8*(i%8) +: 8]) * 32'(byte_weight(5'(i)));
    n = (nbkt_reg == 0) ? 255 : ((nbkt_reg > NBKT) ? NBKT : int'(nbkt_reg));
    return int'(h % 32'(n));
  endfunction

  function automatic int oldest_match(int base, req_t r);
    int best;
    logic [31:0] age, best_age;
    best = -1;
    best_age = '0;
    for (int k = 0; k < NWAY; k++) begin
      if (tv_valid[base+k] && tv_entry[base+k].x == r.origin_x &&
          tv_entry[base+k].y == r.origin_y && tv_entry[base+k].z == r.origin_z &&
          tv_entry[base+k].level == r.res_level) begin
        age = ins_seq - tv_entry[base+k].stamp;
        if (best < 0 || age > best_age) begin
          best = base + k;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic rsp_t apply_lookup(req_t r);
    rsp_t o;
    int base, s;
    logic [48:0] sum;
    base = bucket_of(r) * NWAY;
    o.status = ST_MISS;
    o.found_handle = '0;
    if (r.opcode == OP_INSERT) begin
      s = -1;
      for (int k = NWAY - 1; k >= 0; k--) if (!tv_valid[base+k]) s = base + k;
      if (s < 0) o.status = ST_FULL;
      else begin
        tv_valid[s] = 1'b1;
        tv_entry[s] = '{r.origin_x, r.origin_y, r.origin_z, r.res_level,
                        r.tile_handle, r.tile_bytes, ins_seq};
        ins_seq++;
        sum = tot_bytes + r.tile_bytes;
        tot_bytes = sum[48] ? TOTAL_MAX : sum[47:0];
        o.status = ST_OK;
        o.found_handle = r.tile_handle;
      end
    end else if (r.opcode == OP_GET || r.opcode == OP_REMOVE) begin
      s = oldest_match(base, r);
      if (s >= 0) begin
        o.status = ST_OK;
        o.found_handle = tv_entry[s].handle;
        if (r.opcode == OP_REMOVE) begin
          tv_valid[s] = 1'b0;
          tot_bytes = (tot_bytes >= tv_entry[s].size) ? tot_bytes - tv_entry[s].size : '0;
        end
      end
    end
    o.total_bytes = tot_bytes;
    return o;
  endfunction

  // handshakes seen at the last rising edge
  logic req_taken, rsp_taken;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
      rsp_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      rsp_taken <= rsp_valid && !rsp_stall;
    end
  end

  // driver
  int gap;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
      req <= '0;
      gap <= 0;
    end else if (req_valid && req_taken) begin
      if (gap == 0 && pending_reqs.size() > 0 && $urandom_range(0, 3) != 0) begin
        req <= pending_reqs.pop_front();
        gap <= $urandom_range(0, 13);
      end else begin
        req_valid <= 1'b0;
      end
    end else if (!req_valid) begin
      if (gap > 0) gap <= gap - 1;
      else if (pending_reqs.size() > 0) begin
        req_valid <= 1'b1;
        req <= pending_reqs.pop_front();
        gap <= $urandom_range(0, 13);
      end
    end
  end

  // receiver stall
  int rgap;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_stall <= 1'b0;
      rgap <= 0;
    end else if (hold_off > 0) begin
      rsp_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (rgap > 0) begin
      rsp_stall <= 1'b1;
      if (rsp_valid) rgap <= rgap - 1;
    end else begin
      rsp_stall <= 1'b0;
      if (rsp_taken) rgap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    end
  end

  // monitor
  rsp_t exp_rsp;
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_valid && !req_stall) expected_rsps.push_back(apply_lookup(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response word with nothing expected");
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp.status !== exp_rsp.status) begin
            $error("status exp %0d got %0d", exp_rsp.status, rsp.status);
            errors++;
          end
          if (rsp.found_handle !== exp_rsp.found_handle) begin
            $error("found_handle exp %h got %h", exp_rsp.found_handle, rsp.found_handle);
            errors++;
          end
          if (rsp.total_bytes !== exp_rsp.total_bytes) begin
            $error("total_bytes exp %h got %h", exp_rsp.total_bytes, rsp.total_bytes);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || stim_done)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  req_t keys[$];

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t mk(logic [1:0] op, req_t k, logic [31:0] hd, logic [31:0] by);
    req_t r;
    r = k;
    r.opcode = op;
    r.tile_handle = hd;
    r.tile_bytes = by;
    return r;
  endfunction

  function automatic req_t rand_key();
    req_t r;
    int sel;
    r = '0;
    sel = $urandom_range(0, 3);
    r.origin_x = (sel == 0) ? 64'(0) : (sel == 1 ? '1 : rand64());
    r.origin_y = rand64();
    r.origin_z = ($urandom_range(0, 1) != 0) ? rand64() : 64'(0);
    r.res_level = 8'($urandom());
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [8:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    nbkt_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    req_t k;
    logic [31:0] by;
    for (int i = 0; i < n; i++) begin
      if (keys.size() == 0 || $urandom_range(0, 2) == 0) begin
        k = rand_key();
        keys.push_back(k);
        if (keys.size() > 40) void'(keys.pop_front());
      end else k = keys[$urandom_range(0, keys.size() - 1)];
      by = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pending_reqs.push_back(mk(OP_INSERT, k, $urandom(), by));
        4, 5, 6:    pending_reqs.push_back(mk(OP_GET, k, $urandom(), $urandom()));
        7, 8:       pending_reqs.push_back(mk(OP_REMOVE, k, $urandom(), $urandom()));
        default:    pending_reqs.push_back(mk(OP_NOP, k, $urandom(), $urandom()));
      endcase
    end
  endtask

  req_t kz, ko;
  initial begin
    errors = 0;
    hold_off = 0;
    stim_done = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    ins_seq = '0;
    tot_bytes = '0;
    nbkt_reg = BUCKET_COUNT_RESET;
    for (int i = 0; i < NBKT*NWAY; i++) begin
      tv_valid[i] = 1'b0;
      tv_entry[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    kz = '0;
    ko = '1;
    // duplicate keys, full bucket, oldest match, misses
    for (int i = 0; i < 5; i++) pending_reqs.push_back(mk(OP_INSERT, ko, 32'(i + 1), '1));
    pending_reqs.push_back(mk(OP_GET, ko, '0, '0));
    pending_reqs.push_back(mk(OP_REMOVE, ko, '0, '0));
    pending_reqs.push_back(mk(OP_GET, ko, '0, '0));
    pending_reqs.push_back(mk(OP_INSERT, kz, '1, '0));
    pending_reqs.push_back(mk(OP_GET, kz, '0, '0));
    pending_reqs.push_back(mk(OP_REMOVE, kz, '0, '0));
    pending_reqs.push_back(mk(OP_REMOVE, kz, '0, '0));
    pending_reqs.push_back(mk(OP_NOP, ko, '1, '1));
    pending_reqs.push_back(mk(OP_GET, rand_key(), '0, '0));
    wait_drained();

    // long receiver hold-off while requests keep coming
    hold_off = 400;
    random_phase(300);
    wait_drained();

    write_bucket_count(9'd1);
    random_phase(250);
    wait_drained();
    write_bucket_count(9'd0);
    random_phase(250);
    wait_drained();
    write_bucket_count(9'd511);
    random_phase(300);
    wait_drained();
    write_bucket_count(9'd256);
    random_phase(300);
    wait_drained();
    write_bucket_count(9'd3);
    // shrink the bucket count so full buckets get hit
    for (int i = 0; i < 20; i++) pending_reqs.push_back(mk(OP_INSERT, rand_key(), $urandom(), '1));
    random_phase(250);
    wait_drained();
    write_bucket_count(9'($urandom_range(1, 256)));
    random_phase(200);
    wait_drained();

    stim_done = 1'b1;
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
